[rtl/core/mfap_pkg.sv]
package mfap_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;

    localparam int VC_W    = 7;
    localparam int CAP_W   = 16;
    localparam int LIM_W   = 17;
    localparam int FLOW_W  = 24;

    localparam logic [LIM_W-1:0]  START_LIMIT = 17'd100000;
    localparam logic [FLOW_W-1:0] FLOW_MAX    = 24'hFFFFFF;

endpackage

[rtl/core/mfap_ram.sv]
module mfap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

[rtl/core/max_flow_augmenting_path.sv]
// A stored edge passes IDLE, L1, L2 and L3; a dropped edge IDLE alone. Solving starts
// on the last edge: each search begins with HEAD, INIT; each entry examined takes EXAM,
// EVAL (and PUSH on a descent); each pop EXAM, POP, POP2; each augmented hop AU1, AU2,
// AU3. The input stalls while an edge is stored and after the last edge until the
// result is loaded. Synchronous active-low reset clears the lists, entry count, output
// valid and vertex count (to 2); entry memories hold no reset value.
module max_flow_augmenting_path #(
    parameter int MAX_VERTICES = mfap_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = mfap_pkg::MAX_EDGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mfap_pkg::VC_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mfap_pkg::VC_W-1:0]     i_src_vertex,
    input  logic [mfap_pkg::VC_W-1:0]     i_dst_vertex,
    input  logic [mfap_pkg::CAP_W-1:0]    i_capacity,
    input  logic                          i_last_edge,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mfap_pkg::FLOW_W-1:0]   o_max_flow
);

    import mfap_pkg::*;

    localparam int SLOTS = 2 * MAX_EDGES;
    localparam int EW    = $clog2(SLOTS);
    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CW    = EW + 1;
    localparam int SW    = EW + LIM_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_L1   = 4'd1;
    localparam logic [3:0] ST_L2   = 4'd2;
    localparam logic [3:0] ST_L3   = 4'd3;
    localparam logic [3:0] ST_HEAD = 4'd4;
    localparam logic [3:0] ST_INIT = 4'd5;
    localparam logic [3:0] ST_EXAM = 4'd6;
    localparam logic [3:0] ST_EVAL = 4'd7;
    localparam logic [3:0] ST_PUSH = 4'd8;
    localparam logic [3:0] ST_POP  = 4'd9;
    localparam logic [3:0] ST_POP2 = 4'd10;
    localparam logic [3:0] ST_AU1  = 4'd11;
    localparam logic [3:0] ST_AU2  = 4'd12;
    localparam logic [3:0] ST_AU3  = 4'd13;
    localparam logic [3:0] ST_DONE = 4'd14;

    localparam logic [EW:0] NULL_PTR = {1'b1, {EW{1'b0}}};

    logic [3:0]              r_st, n_st;
    logic [VC_W-1:0]         r_vc;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [MAX_VERTICES-1:0] r_hv, n_hv;
    logic [MAX_VERTICES-1:0] r_vis, n_vis;
    logic [VW-1:0]           r_src, n_src;
    logic [VW-1:0]           r_dst, n_dst;
    logic                    r_last, n_last;
    logic [EW:0]             r_cur, n_cur;
    logic [LIM_W-1:0]        r_lim, n_lim;
    logic [VW-1:0]           r_dep, n_dep;
    logic [VW-1:0]           r_t, n_t;
    logic [VW-1:0]           r_k, n_k;
    logic [EW-1:0]           r_f, n_f;
    logic [CAP_W-1:0]        r_aug, n_aug;
    logic [FLOW_W-1:0]       r_tot, n_tot;
    logic                    r_ov, n_ov;
    logic [FLOW_W-1:0]       r_out, n_out;

    logic          tgt_we;
    logic [EW-1:0] tgt_wa, tgt_ra;
    logic [VW-1:0] tgt_wd, tgt_q;
    logic             res_we;
    logic [EW-1:0]    res_wa, res_ra;
    logic [CAP_W-1:0] res_wd, res_q;
    logic          nxt_we;
    logic [EW-1:0] nxt_wa, nxt_ra;
    logic [EW:0]   nxt_wd, nxt_q;
    logic          hd_we;
    logic [VW-1:0] hd_wa, hd_ra;
    logic [EW-1:0] hd_wd, hd_q;
    logic          tl_we;
    logic [VW-1:0] tl_wa, tl_ra;
    logic [EW-1:0] tl_wd, tl_q;
    logic          stk_we;
    logic [VW-1:0] stk_wa, stk_ra;
    logic [SW-1:0] stk_wd, stk_q;

    logic [VW-1:0]    sink_idx;
    logic [31:0]      sink_n;
    logic             edge_ok;
    logic [CW-1:0]    rev_e;
    logic [LIM_W-1:0] res_ext;
    logic [LIM_W-1:0] new_lim;
    logic [EW-1:0]    path_f;
    logic [FLOW_W:0]  tot_sum;

    always_comb begin
        if (r_vc < VC_W'(2)) begin
            sink_n = 32'd2;
        end else if (32'(r_vc) > 32'(MAX_VERTICES)) begin
            sink_n = 32'(MAX_VERTICES);
        end else begin
            sink_n = 32'(r_vc);
        end
    end
    assign sink_idx = VW'(sink_n - 32'd1);

    assign edge_ok = (i_src_vertex != '0) && (32'(i_src_vertex) <= sink_n) &&
                     (i_dst_vertex != '0) && (32'(i_dst_vertex) <= sink_n) &&
                     (32'(r_cnt) + 32'd2 <= 32'(SLOTS));
    assign rev_e   = r_cnt | CW'(1);
    assign res_ext = {1'b0, res_q};
    assign new_lim = (res_ext < r_lim) ? res_ext : r_lim;
    assign path_f  = (r_k == r_dep) ? r_cur[EW-1:0] : stk_q[SW-1:LIM_W];
    assign tot_sum = {1'b0, r_tot} + (FLOW_W+1)'(r_aug);

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_hv = r_hv; n_vis = r_vis;
        n_src = r_src; n_dst = r_dst; n_last = r_last;
        n_cur = r_cur; n_lim = r_lim; n_dep = r_dep; n_t = r_t; n_k = r_k;
        n_f = r_f; n_aug = r_aug; n_tot = r_tot; n_out = r_out;
        n_ov = r_ov && i_out_stall;
        tgt_we = 1'b0; tgt_wa = '0; tgt_wd = '0; tgt_ra = r_cur[EW-1:0];
        res_we = 1'b0; res_wa = '0; res_wd = '0; res_ra = r_cur[EW-1:0];
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = NULL_PTR; nxt_ra = r_cur[EW-1:0];
        hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
        tl_we = 1'b0; tl_wa = '0; tl_wd = '0; tl_ra = '0;
        stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
        case (r_st)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_src  = VW'(i_src_vertex - VC_W'(1));
                    n_dst  = VW'(i_dst_vertex - VC_W'(1));
                    n_last = i_last_edge;
                    n_tot  = '0;
                    if (edge_ok) begin
                        tgt_we = 1'b1; tgt_wa = r_cnt[EW-1:0];
                        tgt_wd = VW'(i_dst_vertex - VC_W'(1));
                        res_we = 1'b1; res_wa = r_cnt[EW-1:0]; res_wd = i_capacity;
                        nxt_we = 1'b1; nxt_wa = r_cnt[EW-1:0]; nxt_wd = NULL_PTR;
                        tl_ra  = VW'(i_src_vertex - VC_W'(1));
                        n_st   = ST_L1;
                    end else begin
                        n_st = i_last_edge ? ST_HEAD : ST_IDLE;
                    end
                end
            end
            ST_L1: begin
                tgt_we = 1'b1; tgt_wa = rev_e[EW-1:0]; tgt_wd = r_src;
                res_we = 1'b1; res_wa = rev_e[EW-1:0]; res_wd = '0;
                if (r_hv[r_src]) begin
                    nxt_we = 1'b1; nxt_wa = tl_q; nxt_wd = {1'b0, r_cnt[EW-1:0]};
                end else begin
                    hd_we = 1'b1; hd_wa = r_src; hd_wd = r_cnt[EW-1:0];
                end
                tl_we = 1'b1; tl_wa = r_src; tl_wd = r_cnt[EW-1:0];
                n_hv[r_src] = 1'b1;
                n_st = ST_L2;
            end
            ST_L2: begin
                nxt_we = 1'b1; nxt_wa = rev_e[EW-1:0]; nxt_wd = NULL_PTR;
                tl_ra  = r_dst;
                n_st   = ST_L3;
            end
            ST_L3: begin
                if (r_hv[r_dst]) begin
                    nxt_we = 1'b1; nxt_wa = tl_q; nxt_wd = {1'b0, rev_e[EW-1:0]};
                end else begin
                    hd_we = 1'b1; hd_wa = r_dst; hd_wd = rev_e[EW-1:0];
                end
                tl_we = 1'b1; tl_wa = r_dst; tl_wd = rev_e[EW-1:0];
                n_hv[r_dst] = 1'b1;
                n_cnt = r_cnt + CW'(2);
                n_st  = r_last ? ST_HEAD : ST_IDLE;
            end
            ST_HEAD: begin
                hd_ra = '0;
                n_st  = ST_INIT;
            end
            ST_INIT: begin
                n_cur = r_hv[0] ? {1'b0, hd_q} : NULL_PTR;
                n_lim = START_LIMIT;
                n_dep = '0;
                n_vis = '0;
                n_vis[0] = 1'b1;
                n_st  = ST_EXAM;
            end
            ST_EXAM: begin
                if (r_cur[EW]) begin
                    if (r_dep == '0) begin
                        n_st = ST_DONE;
                    end else begin
                        stk_ra = r_dep - VW'(1);
                        n_dep  = r_dep - VW'(1);
                        n_st   = ST_POP;
                    end
                end else begin
                    n_st = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_cur = nxt_q;
                n_st  = ST_EXAM;
                if (!r_vis[tgt_q] && res_q != '0) begin
                    if (tgt_q == sink_idx) begin
                        n_aug  = new_lim[CAP_W-1:0];
                        n_k    = '0;
                        stk_ra = '0;
                        n_cur  = r_cur;
                        n_st   = ST_AU1;
                    end else if (32'(r_dep) != 32'(MAX_VERTICES - 1)) begin
                        stk_we = 1'b1; stk_wa = r_dep; stk_wd = {r_cur[EW-1:0], r_lim};
                        n_dep  = r_dep + VW'(1);
                        n_vis[tgt_q] = 1'b1;
                        n_lim  = new_lim;
                        n_t    = tgt_q;
                        hd_ra  = tgt_q;
                        n_cur  = r_cur;
                        n_st   = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                n_cur = r_hv[r_t] ? {1'b0, hd_q} : NULL_PTR;
                n_st  = ST_EXAM;
            end
            ST_POP: begin
                n_cur  = {1'b0, stk_q[SW-1:LIM_W]};
                n_lim  = stk_q[LIM_W-1:0];
                nxt_ra = stk_q[SW-1:LIM_W];
                n_st   = ST_POP2;
            end
            ST_POP2: begin
                n_cur = nxt_q;
                n_st  = ST_EXAM;
            end
            ST_AU1: begin
                n_f    = path_f;
                res_ra = path_f;
                n_st   = ST_AU2;
            end
            ST_AU2: begin
                res_we = 1'b1; res_wa = r_f; res_wd = res_q - r_aug;
                res_ra = r_f ^ EW'(1);
                n_st   = ST_AU3;
            end
            ST_AU3: begin
                res_we = 1'b1; res_wa = r_f ^ EW'(1); res_wd = res_q + r_aug;
                if (r_k == r_dep) begin
                    n_tot = tot_sum[FLOW_W] ? FLOW_MAX : tot_sum[FLOW_W-1:0];
                    n_st  = ST_HEAD;
                end else begin
                    n_k    = r_k + VW'(1);
                    stk_ra = r_k + VW'(1);
                    n_st   = ST_AU1;
                end
            end
            ST_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov  = 1'b1;
                    n_out = r_tot;
                    n_hv  = '0;
                    n_cnt = '0;
                    n_st  = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_vc  <= VC_W'(2);
            r_cnt <= '0;
            r_hv  <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            if (i_cfg_we) begin
                r_vc <= i_cfg_data;
            end
            r_cnt <= n_cnt;
            r_hv  <= n_hv;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vis  <= n_vis;
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_last <= n_last;
        r_cur  <= n_cur;
        r_lim  <= n_lim;
        r_dep  <= n_dep;
        r_t    <= n_t;
        r_k    <= n_k;
        r_f    <= n_f;
        r_aug  <= n_aug;
        r_tot  <= n_tot;
        r_out  <= n_out;
    end

    mfap_ram #(.WIDTH(VW), .DEPTH(SLOTS)) u_tgt (
        .i_clk(i_clk), .i_we(tgt_we), .i_waddr(tgt_wa), .i_wdata(tgt_wd),
        .i_raddr(tgt_ra), .o_rdata(tgt_q));
    mfap_ram #(.WIDTH(CAP_W), .DEPTH(SLOTS)) u_res (
        .i_clk(i_clk), .i_we(res_we), .i_waddr(res_wa), .i_wdata(res_wd),
        .i_raddr(res_ra), .o_rdata(res_q));
    mfap_ram #(.WIDTH(EW+1), .DEPTH(SLOTS)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(nxt_ra), .o_rdata(nxt_q));
    mfap_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_raddr(hd_ra), .o_rdata(hd_q));
    mfap_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_tail (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(tl_wa), .i_wdata(tl_wd),
        .i_raddr(tl_ra), .o_rdata(tl_q));
    mfap_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_q));

    assign o_in_stall  = (r_st != ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_max_flow  = r_out;

`ifndef ASSERT_OFF
    a_cnt_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cnt[0] && (32'(r_cnt) <= 32'(SLOTS)))
        else $error("entry count out of range");
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DONE && (!r_ov || !i_out_stall)) |=>
        (r_st == ST_IDLE && r_cnt == '0 && r_hv == '0 && r_ov))
        else $error("solve end did not clear graph");
    a_src_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EXAM || r_st == ST_EVAL) |-> r_vis[0])
        else $error("source not marked during search");
    a_aug_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_AU1 || r_st == ST_AU2 || r_st == ST_AU3) |-> (r_aug != '0))
        else $error("zero augmentation");
`endif

endmodule
